/* hdl/bffa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-free allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int POS_W  = 13;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ACCESS,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage : bffa_pkg
`default_nettype wire

/* hdl/bitmap_first_free_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// Free/used bitmap of MAP_BITS positions with read, write and find-first-free.
// ----------------------------------------------------------------------------
// The map sits in one single-port-read, single-port-write memory of
// ceil(MAP_BITS / WORD_BITS) words of WORD_BITS bits, and the block handles
// one command at a time. After reset a clearing pass writes every word to
// zero, one word per cycle, and no input word is taken during it. A read or
// a write passes through a reciprocal multiply that gives the word index,
// one memory read with the bit index taken from the remainder, the check or
// the write-back, then the output load, after which the next command is
// taken; a position outside the map skips the memory. A find reads the
// memory one word per cycle from word 0 up and stops at the first word with
// a free bit, or after the last word with the map full. The output load
// waits while an earlier result is still held. Each command gives one
// result word; a new command is taken while that result waits.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
    import bffa_pkg::*;
#(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output      logic             s_axis_tready,
    // [1:0] command, [14:2] position, [15] new_value
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output      logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [0] bit_read, [13:1] free_index, [14] map_full, [15] zero
    output      logic [OUT_W-1:0] m_axis_tdata
);

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int LAST_BITS = MAP_BITS - (MAP_WORDS - 1) * WORD_BITS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);

    localparam int DIV_SH    = POS_W + BIT_W;
    localparam int MUL_W     = POS_W + 1;
    localparam int PROD_W    = POS_W + MUL_W;
    localparam int QUOT_W    = PROD_W - DIV_SH;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    // ------------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------------
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   scan_addr_reg;
    logic                scan_live_reg;
    logic                chk_vld_reg;
    logic                chk_last_reg;
    logic                out_vld_reg;

    cmd_t                cmd_reg;
    logic                val_reg;
    logic                in_map_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [ADDR_W-1:0]   word_reg;
    logic [BIT_W-1:0]    rem_reg;
    logic [POS_W-1:0]    base_reg;
    logic                res_bit_reg;
    logic [POS_W-1:0]    res_idx_reg;
    logic                res_full_reg;
    logic                out_bit_reg;
    logic [POS_W-1:0]    out_idx_reg;
    logic                out_full_reg;

    logic                in_fire;
    logic                out_fire;
    logic                out_load;
    cmd_t                in_cmd;
    logic [POS_W-1:0]    in_pos;
    logic [PROD_W-1:0]   quot_prod;
    logic [QUOT_W-1:0]   quot_word;
    logic [POS_W-1:0]    word_base;
    logic [POS_W-1:0]    rem_full;
    logic [WORD_BITS-1:0] last_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                found;
    logic [BIT_W-1:0]    first_k;
    logic [BIT_W-1:0]    bit_idx;
    logic [WORD_BITS-1:0] word_mod;

    assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
    assign in_pos   = s_axis_tdata[POS_W+1:2];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = out_vld_reg && m_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_vld_reg || m_axis_tready);

    assign quot_prod = PROD_W'(pos_reg) * PROD_W'(DIV_MUL);
    assign quot_word = quot_prod[PROD_W-1:DIV_SH];
    assign word_base = POS_W'(32'(word_reg) * WORD_BITS);
    assign rem_full  = pos_reg - word_base;
    assign bit_idx   = rem_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            last_mask[j] = (j < LAST_BITS);
        end
    end

    assign free_bits = ~rd_data_reg & (chk_last_reg ? last_mask : '1);
    assign found     = chk_vld_reg && (|free_bits);

    always_comb
    begin
        first_k = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                first_k = BIT_W'(j);
            end
        end
    end

    always_comb
    begin
        word_mod          = rd_data_reg;
        word_mod[bit_idx] = val_reg;
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_cmd)
                        CMD_READ:  state_next = ST_DIV;
                        CMD_WRITE: state_next = ST_DIV;
                        CMD_FIND:  state_next = ST_SCAN;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV:
            begin
                state_next = in_map_reg ? ST_ACCESS : ST_DONE;
            end
            ST_ACCESS:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (found || (chk_vld_reg && chk_last_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Memory controls
    // ------------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = scan_addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = scan_addr_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_ACCESS:
            begin
                mem_re    = 1'b1;
                mem_raddr = word_reg;
            end
            ST_MODIFY:
            begin
                mem_we    = (cmd_reg == CMD_WRITE);
                mem_waddr = word_reg;
                mem_wdata = word_mod;
            end
            ST_SCAN:
            begin
                mem_re = scan_live_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_addr_reg <= '0;
            scan_live_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            chk_last_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (scan_addr_reg != LAST_ADDR)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    scan_addr_reg <= '0;
                    scan_live_reg <= 1'b1;
                    chk_vld_reg   <= 1'b0;
                    chk_last_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    chk_vld_reg <= scan_live_reg;
                    if (scan_live_reg)
                    begin
                        chk_last_reg <= (scan_addr_reg == LAST_ADDR);
                        if (scan_addr_reg == LAST_ADDR)
                        begin
                            scan_live_reg <= 1'b0;
                        end
                        else
                        begin
                            scan_addr_reg <= scan_addr_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    chk_vld_reg <= chk_vld_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg      <= in_cmd;
                val_reg      <= s_axis_tdata[POS_W+2];
                in_map_reg   <= (32'(in_pos) < 32'(MAP_BITS));
                pos_reg      <= in_pos;
                word_reg     <= '0;
                rem_reg      <= '0;
                base_reg     <= '0;
                res_bit_reg  <= 1'b0;
                res_idx_reg  <= '0;
                res_full_reg <= 1'b0;
            end
            ST_DIV:
            begin
                word_reg <= ADDR_W'(quot_word);
            end
            ST_ACCESS:
            begin
                rem_reg <= rem_full[BIT_W-1:0];
            end
            ST_MODIFY:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    res_bit_reg <= rd_data_reg[bit_idx];
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    res_idx_reg <= base_reg + POS_W'(first_k);
                end
                else if (chk_vld_reg)
                begin
                    base_reg <= base_reg + POS_W'(WORD_BITS);
                    if (chk_last_reg)
                    begin
                        res_full_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
                base_reg <= base_reg;
            end
        endcase
        if (out_load)
        begin
            out_bit_reg  <= res_bit_reg;
            out_idx_reg  <= res_idx_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_full_reg, out_idx_reg, out_bit_reg};

endmodule : bitmap_first_free_allocator
`default_nettype wire

/* tb/tb_bitmap_first_free_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_free_allocator
// Self-checking bench for the first-free bitmap allocator: streams read,
// write, find and unused commands through the slave side, tracks the map in a
// local copy, and compares every result word on the master side in order.
// Covers an empty map, the low words filled one by one with a find at each
// boundary, and a random mix of frees, allocations, reads and finds, under
// random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_first_free_allocator;
    import bffa_pkg::*;

    localparam int MAP_BITS    = 8192;
    localparam int WORD_BITS   = 64;
    localparam int FILL_BITS   = 4 * WORD_BITS;
    localparam int RANDOM_CMDS = 620;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 150;
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        logic             map_full;
        logic [POS_W-1:0] free_index;
        logic             bit_read;
    } alloc_result_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [IN_W-1:0] pending_cmds [$];
    alloc_result_t   expected_results [$];
    bit              usage_map [MAP_BITS];

    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_cycles;
    int unsigned cycle_count;
    int          words_in;
    int          words_out;
    int          hold_at_a;
    int          hold_at_b;
    int          error_count;
    int          n_read;
    int          n_write;
    int          n_find;
    int          n_full;
    int          n_unused;
    bit          stimulus_ready;
    bit          steady_flow;
    alloc_result_t got;
    alloc_result_t want;

    bitmap_first_free_allocator #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got_v, input int exp_v);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 words_out, what, got_v, exp_v);
        error_count++;
    endtask

    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [IN_W-1:0] pack_cmd(cmd_t cmd, int pos, bit val);
        logic [POS_W-1:0] p;
        p = pos[POS_W-1:0];
        return {val, p, cmd};
    endfunction

    function automatic int pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 0;
            1: return MAP_BITS - 1;
            2: return WORD_BITS * $urandom_range(0, MAP_BITS / WORD_BITS - 1);
            3: return WORD_BITS * $urandom_range(1, MAP_BITS / WORD_BITS) - 1;
            4: return $urandom_range(0, 1023);
            default: return $urandom_range(0, MAP_BITS - 1);
        endcase
    endfunction

    // apply one command to the local map and return the result it must give
    function automatic alloc_result_t allocator_step(logic [IN_W-1:0] w);
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        alloc_result_t    r;
        bit               found;
        cmd   = cmd_t'(w[1:0]);
        pos   = w[POS_W+1:2];
        r     = '0;
        found = 1'b0;
        case (cmd)
            CMD_READ:
            begin
                r.bit_read = usage_map[pos];
                n_read++;
            end
            CMD_WRITE:
            begin
                usage_map[pos] = w[IN_W-1];
                n_write++;
            end
            CMD_FIND:
            begin
                for (int i = 0; i < MAP_BITS; i++)
                begin
                    if (!found && !usage_map[i])
                    begin
                        r.free_index = i[POS_W-1:0];
                        found        = 1'b1;
                    end
                end
                r.map_full = !found;
                n_find++;
                if (!found)
                    n_full++;
            end
            default:
            begin
                n_unused++;
            end
        endcase
        return r;
    endfunction

    // driver: present queued command words, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
            words_in      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(allocator_step(s_axis_tdata));
                words_in <= words_in + 1;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the word until taken
            end
            else if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (stimulus_ready && pending_cmds.size() != 0)
            begin
                s_axis_tdata  <= pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap      <= next_gap();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started at two chosen input words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
        else if (s_axis_tvalid && s_axis_tready && (words_in == hold_at_a || words_in == hold_at_b))
            hold_cycles <= LONG_HOLD;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end
        else if (hold_cycles != 0)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap != 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= recv_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready)
                recv_gap <= next_gap();
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[POS_W+1:0];
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", int'(m_axis_tdata), -1);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.bit_read !== want.bit_read)
                    report_mismatch("bit_read", got.bit_read, want.bit_read);
                if (got.free_index !== want.free_index)
                    report_mismatch("free_index", got.free_index, want.free_index);
                if (got.map_full !== want.map_full)
                    report_mismatch("map_full", got.map_full, want.map_full);
                if (m_axis_tdata[OUT_W-1] !== 1'b0)
                    report_mismatch("pad bit", m_axis_tdata[OUT_W-1], 0);
            end
            words_out <= words_out + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 2000 == 0)
            steady_flow <= ($urandom_range(0, 3) == 0);
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        int          pos;
        rst_n          = 1'b0;
        stimulus_ready = 1'b0;
        steady_flow    = 1'b0;
        cycle_count    = 0;
        words_out      = 0;
        error_count    = 0;
        n_read         = 0;
        n_write        = 0;
        n_find         = 0;
        n_full         = 0;
        n_unused       = 0;
        hold_at_a      = 12;

        // empty map, extremes, unused command, ignored fields
        pending_cmds.push_back(pack_cmd(CMD_FIND, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_READ, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_READ, MAP_BITS - 1, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_NONE, MAP_BITS - 1, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_NONE, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_READ, MAP_BITS - 1, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, 0, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_FIND, MAP_BITS - 1, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, MAP_BITS - 1, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_READ, MAP_BITS - 1, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_FIND, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_READ, 0, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, MAP_BITS - 1, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_READ, MAP_BITS - 1, 1'b0));

        // fill the low words, find at each word boundary
        for (int p = 0; p < FILL_BITS; p++)
        begin
            pending_cmds.push_back(pack_cmd(CMD_WRITE, p, 1'b1));
            if (p % WORD_BITS == WORD_BITS - 1)
                pending_cmds.push_back(pack_cmd(CMD_FIND, $urandom_range(0, MAP_BITS - 1),
                                                $urandom_range(0, 1)));
            if (p % 512 == 5)
                pending_cmds.push_back(pack_cmd(CMD_READ, p, 1'b0));
        end
        pending_cmds.push_back(pack_cmd(CMD_READ, 4097, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, MAP_BITS - 1, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_FIND, 0, 1'b0));
        pending_cmds.push_back(pack_cmd(CMD_WRITE, MAP_BITS - 1, 1'b1));
        pending_cmds.push_back(pack_cmd(CMD_FIND, MAP_BITS - 1, 1'b1));
        hold_at_b = pending_cmds.size() + 300;

        // random mix: scattered frees, allocations low in the map, reads, finds
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                pending_cmds.push_back(pack_cmd(CMD_NONE, $urandom_range(0, MAP_BITS - 1),
                                                $urandom_range(0, 1)));
            else if (r < 28)
                pending_cmds.push_back(pack_cmd(CMD_READ, pick_position(),
                                                $urandom_range(0, 1)));
            else if (r < 58)
                pending_cmds.push_back(pack_cmd(CMD_FIND, $urandom_range(0, MAP_BITS - 1),
                                                $urandom_range(0, 1)));
            else if (r < 79)
                pending_cmds.push_back(pack_cmd(CMD_WRITE, pick_position(), 1'b0));
            else
            begin
                pos = ($urandom_range(0, 3) == 0) ? pick_position() : $urandom_range(0, 1023);
                pending_cmds.push_back(pack_cmd(CMD_WRITE, pos, 1'b1));
            end
        end

        repeat (6) @(posedge clk);
        rst_n          <= 1'b1;
        stimulus_ready <= 1'b1;

        while (pending_cmds.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d command words, %0d result words checked in %0d cycles",
                 words_in, words_out, cycle_count);
        $display("reads %0d, writes %0d, finds %0d (%0d on a full map), unused %0d",
                 n_read, n_write, n_find, n_full, n_unused);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
